// ===== rtl/sve_pkg.sv =====
// ----------------------------------------------------------------------------
// sve_pkg
// Shared widths, constants, register codes and types of the signed velocity
// estimator.
// ----------------------------------------------------------------------------
package sve_pkg;

    localparam int DIV_W   = 53;   // serial divider dividend / quotient
    localparam int DVS_W   = 24;   // serial divider divisor / remainder
    localparam int CNT_W   = 6;    // iteration counters
    localparam int SQ_IN_W = 33;   // |dx|, |dy|
    localparam int SQ_W    = 66;   // squares and their sum
    localparam int RT_W    = 34;   // square root result
    localparam int RAD_W   = 68;   // radicand padded to an even width
    localparam int REM_W   = 37;   // square root partial remainder
    localparam int WINDOW  = 50;
    localparam int PTR_W   = 6;
    localparam int SUM_W   = 38;

    localparam logic [19:0]        US_PER_S  = 20'd1000000;
    localparam logic [DVS_W-1:0]   BAND_2P   = 24'd411698;
    localparam logic [DVS_W-1:0]   WIN_DIV   = DVS_W'(WINDOW);
    localparam logic signed [32:0] BAND_P    = 33'sd205849;
    localparam logic signed [32:0] BAND_HP   = 33'sd102924;
    // P plus 8192 turns of 2P: keeps h + P positive without changing h mod 2P
    localparam logic [33:0]        WRAP_OFFS = 34'd3372835865;
    localparam logic [31:0]        I32_MAX   = 32'h7fffffff;
    localparam logic [31:0]        I32_MIN   = 32'h80000000;

    localparam logic [15:0] SPEED_DB_RST  = 16'd983;
    localparam logic [15:0] RATE_DB_RST   = 16'd655;
    localparam logic [19:0] TIME_STEP_RST = 20'd9524;

    localparam logic [1:0] CFG_SPEED_DB  = 2'd0;
    localparam logic [1:0] CFG_RATE_DB   = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQR,
        ST_ROOTS,
        ST_ROOT,
        ST_MUL,
        ST_DIVS,
        ST_DIV,
        ST_RD,
        ST_WIN,
        ST_AVGS,
        ST_AVG,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } win_ctrl_t;

endpackage

// ===== rtl/sve_div.sv =====
// ----------------------------------------------------------------------------
// sve_div
// Restoring divider, one quotient bit per cycle, MSB of the dividend first.
// ----------------------------------------------------------------------------
module sve_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sve_pkg::DIV_W-1:0]     dividend,
    input  logic [sve_pkg::DVS_W-1:0]     divisor,
    output logic                          done,
    output logic [sve_pkg::DIV_W-1:0]     quot,
    output logic [sve_pkg::DVS_W-1:0]     rem
);

    logic [sve_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [sve_pkg::DIV_W-1:0] q_reg, q_next;
    logic [sve_pkg::DVS_W-1:0] r_reg, r_next;
    logic [sve_pkg::DVS_W-1:0] d_reg, d_next;
    logic [sve_pkg::DVS_W:0]   trial;
    logic                      ge;

    always_comb
    begin
        trial     = {r_reg, q_reg[sve_pkg::DIV_W-1]};
        ge        = trial >= {1'b0, d_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? sve_pkg::DVS_W'(trial - {1'b0, d_reg})
                          : trial[sve_pkg::DVS_W-1:0];
            q_next   = {q_reg[sve_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sve_pkg::CNT_W'(sve_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ===== rtl/sve_sqr.sv =====
// ----------------------------------------------------------------------------
// sve_sqr
// Bit-serial squarer: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
module sve_sqr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sve_pkg::SQ_IN_W-1:0]   a,
    output logic                          done,
    output logic [sve_pkg::SQ_W-1:0]      prod
);

    logic [sve_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [sve_pkg::SQ_IN_W-1:0] a_reg, a_next;
    logic [sve_pkg::SQ_W-1:0]    m_reg, m_next;
    logic [sve_pkg::SQ_W-1:0]    acc_reg, acc_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            a_next    = a;
            m_next    = sve_pkg::SQ_W'(a);
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
                acc_next = acc_reg + m_reg;
            m_next   = {m_reg[sve_pkg::SQ_W-2:0], 1'b0};
            a_next   = {1'b0, a_reg[sve_pkg::SQ_IN_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sve_pkg::CNT_W'(sve_pkg::SQ_IN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/sve_sqrt.sv =====
// ----------------------------------------------------------------------------
// sve_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sve_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sve_pkg::SQ_W-1:0]    rad,
    output logic                        done,
    output logic [sve_pkg::RT_W-1:0]    root
);

    logic [sve_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [sve_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [sve_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [sve_pkg::RT_W-1:0]  root_reg, root_next;
    logic [sve_pkg::REM_W-1:0] r2;
    logic [sve_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb
    begin
        r2        = {rem_reg[sve_pkg::REM_W-3:0], rad_reg[sve_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = r2 >= trial;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            rad_next  = sve_pkg::RAD_W'(rad);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? r2 - trial : r2;
            root_next = {root_reg[sve_pkg::RT_W-2:0], ge};
            rad_next  = {rad_reg[sve_pkg::RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == sve_pkg::CNT_W'(sve_pkg::RT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/sve_win.sv =====
// ----------------------------------------------------------------------------
// sve_win
// Moving-average window: sample memory with per-entry valid bits, write
// pointer and the two running sums.
// ----------------------------------------------------------------------------
module sve_win (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sve_pkg::win_ctrl_t                ctrl,
    input  logic signed [31:0]                speed_in,
    input  logic signed [31:0]                rate_in,
    output logic signed [sve_pkg::SUM_W-1:0]  speed_sum,
    output logic signed [sve_pkg::SUM_W-1:0]  rate_sum
);

    logic [63:0]                       mem [0:sve_pkg::WINDOW-1];
    logic [63:0]                       rd_reg;
    logic                              rd_ok_reg, rd_ok_next;
    logic [sve_pkg::WINDOW-1:0]        valid_reg, valid_next;
    logic [sve_pkg::PTR_W-1:0]         ptr_reg, ptr_next;
    logic signed [sve_pkg::SUM_W-1:0]  ssum_reg, ssum_next;
    logic signed [sve_pkg::SUM_W-1:0]  rsum_reg, rsum_next;
    logic [31:0]                       old_s, old_r;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
            rd_reg <= mem[ptr_reg];
        if (ctrl.wr)
            mem[ptr_reg] <= {rate_in, speed_in};
    end

    always_comb
    begin
        // entries never written read as zero
        old_s      = rd_ok_reg ? rd_reg[31:0]  : 32'd0;
        old_r      = rd_ok_reg ? rd_reg[63:32] : 32'd0;
        rd_ok_next = rd_ok_reg;
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        ssum_next  = ssum_reg;
        rsum_next  = rsum_reg;
        if (ctrl.rd)
            rd_ok_next = valid_reg[ptr_reg];
        if (ctrl.wr)
        begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next  = (ptr_reg == sve_pkg::PTR_W'(sve_pkg::WINDOW - 1))
                        ? '0 : ptr_reg + 1'b1;
            ssum_next = ssum_reg + {{6{speed_in[31]}}, speed_in}
                                 - {{6{old_s[31]}}, old_s};
            rsum_next = rsum_reg + {{6{rate_in[31]}}, rate_in}
                                 - {{6{old_r[31]}}, old_r};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
            valid_reg <= '0;
            ptr_reg   <= '0;
            ssum_reg  <= '0;
            rsum_reg  <= '0;
        end
        else
        begin
            rd_ok_reg <= rd_ok_next;
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
            ssum_reg  <= ssum_next;
            rsum_reg  <= rsum_next;
        end
    end

    assign speed_sum = ssum_reg;
    assign rate_sum  = rsum_reg;

endmodule

// ===== rtl/signed_velocity_estimator.sv =====
// ----------------------------------------------------------------------------
// signed_velocity_estimator
// One word in flight: an input word is taken only in the idle state. Each
// word runs through the serial chain squarer -> square root -> divider ->
// average divider. A result waiting at the output holds the block in its
// done state and so blocks the next input. Reset clears the window valid
// bits, sums, pointer, last pose and record time, and loads the deadband /
// time step registers with their defaults.
// ----------------------------------------------------------------------------
module signed_velocity_estimator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x [31:0], pos_y [63:32], heading [95:64], elapsed_us [119:96]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // speed [31:0], yaw_rate [63:32], record_time [95:64]
    output logic [95:0]  m_tdata,
    // div_fault [0]
    output logic [0:0]   m_tuser
);

    sve_pkg::state_t state_reg, state_next;

    logic [15:0] sdb_reg, rdb_reg;
    logic [19:0] tstep_reg;
    logic [31:0] lx_reg, ly_reg, lh_reg;
    logic [31:0] time_reg;
    logic [31:0] rt_reg;
    logic        fault_reg;
    logic [31:0] h_reg;
    logic [23:0] dt_reg;
    logic signed [32:0] dx_reg, dy_reg, dh_reg;
    logic [sve_pkg::DIV_W-1:0] prod_reg;
    logic signed [31:0] v_reg, w_reg;
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        accept, out_load;
    logic        ld_units, sqrt_start, sdiv_start, avg_start;
    sve_pkg::win_ctrl_t wctl;

    logic [32:0] ax, ay, adh;
    logic [33:0] wrap_t;
    logic        sqx_done, sqy_done, sqrt_done, sdiv_done, rdiv_done, mdiv_done;
    logic        as_done, ar_done;
    logic [sve_pkg::SQ_W-1:0]  sqx, sqy;
    logic [sve_pkg::RT_W-1:0]  mag;
    logic [sve_pkg::DIV_W-1:0] sq_q, rt_q, md_q, as_q, ar_q;
    logic [sve_pkg::DVS_W-1:0] sq_r, rt_r, md_r, as_r, ar_r;
    logic signed [sve_pkg::SUM_W-1:0] ssum, rsum;
    logic [sve_pkg::SUM_W-1:0] assum, arsum;

    logic signed [32:0] hs, yaw;
    logic        keep;
    logic [31:0] vm, v_calc, w_calc;
    logic [31:0] avg_s, avg_r, fv, fw, spd_out;

    function automatic logic keep_sign(input logic signed [32:0] dx,
                                       input logic signed [32:0] dy,
                                       input logic signed [32:0] yw);
        logic signed [32:0] ayw;
        logic res;
        ayw = yw[32] ? -yw : yw;
        res = 1'b1;
        if (dx > 0 && dy == 0)      res = ayw > sve_pkg::BAND_HP;
        else if (dx == 0 && dy < 0) res = yw > 0;
        else if (dx < 0 && dy == 0) res = ayw < sve_pkg::BAND_HP;
        else if (dx == 0 && dy > 0) res = yw < 0;
        else if (dx > 0 && dy > 0)  res = yw < -sve_pkg::BAND_HP && yw > -sve_pkg::BAND_P;
        else if (dx > 0 && dy < 0)  res = yw > sve_pkg::BAND_HP && yw < sve_pkg::BAND_P;
        else if (dx < 0 && dy < 0)  res = yw > 0 && yw < sve_pkg::BAND_HP;
        else if (dx < 0 && dy > 0)  res = yw < 0 && yw > -sve_pkg::BAND_HP;
        return res;
    endfunction

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sve_pkg::ST_IDLE:  if (accept) state_next = sve_pkg::ST_LOAD;
            sve_pkg::ST_LOAD:  state_next = sve_pkg::ST_SQR;
            sve_pkg::ST_SQR:   if (sqx_done) state_next = sve_pkg::ST_ROOTS;
            sve_pkg::ST_ROOTS: state_next = sve_pkg::ST_ROOT;
            sve_pkg::ST_ROOT:  if (sqrt_done) state_next = sve_pkg::ST_MUL;
            sve_pkg::ST_MUL:   state_next = sve_pkg::ST_DIVS;
            sve_pkg::ST_DIVS:  state_next = sve_pkg::ST_DIV;
            sve_pkg::ST_DIV:   if (sdiv_done) state_next = sve_pkg::ST_RD;
            sve_pkg::ST_RD:    state_next = sve_pkg::ST_WIN;
            sve_pkg::ST_WIN:   state_next = sve_pkg::ST_AVGS;
            sve_pkg::ST_AVGS:  state_next = sve_pkg::ST_AVG;
            sve_pkg::ST_AVG:   if (as_done) state_next = sve_pkg::ST_DONE;
            sve_pkg::ST_DONE:  if (out_load) state_next = sve_pkg::ST_IDLE;
            default:           state_next = sve_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = state_reg == sve_pkg::ST_IDLE;
        accept     = s_tvalid && s_tready;
        ld_units   = state_reg == sve_pkg::ST_LOAD;
        sqrt_start = state_reg == sve_pkg::ST_ROOTS;
        sdiv_start = state_reg == sve_pkg::ST_DIVS;
        avg_start  = state_reg == sve_pkg::ST_AVGS;
        wctl.rd    = state_reg == sve_pkg::ST_RD;
        wctl.wr    = state_reg == sve_pkg::ST_WIN;
        out_load   = (state_reg == sve_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sve_pkg::ST_IDLE;
            sdb_reg      <= sve_pkg::SPEED_DB_RST;
            rdb_reg      <= sve_pkg::RATE_DB_RST;
            tstep_reg    <= sve_pkg::TIME_STEP_RST;
            lx_reg       <= '0;
            ly_reg       <= '0;
            lh_reg       <= '0;
            time_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sve_pkg::CFG_SPEED_DB:  sdb_reg   <= cfg_data[15:0];
                    sve_pkg::CFG_RATE_DB:   rdb_reg   <= cfg_data[15:0];
                    sve_pkg::CFG_TIME_STEP: tstep_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (accept)
            begin
                lx_reg   <= s_tdata[31:0];
                ly_reg   <= s_tdata[63:32];
                lh_reg   <= s_tdata[95:64];
                time_reg <= time_reg + {12'd0, tstep_reg};
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        ax     = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay     = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        adh    = dh_reg[32] ? 33'(-dh_reg) : 33'(dh_reg);
        wrap_t = {{2{h_reg[31]}}, h_reg} + sve_pkg::WRAP_OFFS;

        hs   = {h_reg[31], h_reg};
        yaw  = (hs > -sve_pkg::BAND_P && hs < sve_pkg::BAND_P)
               ? hs : $signed({9'd0, md_r}) - sve_pkg::BAND_P;
        keep = keep_sign(dx_reg, dy_reg, yaw);

        if (dt_reg == 24'd0)
            vm = (mag != '0) ? sve_pkg::I32_MAX : 32'd0;
        else
            vm = (sq_q > sve_pkg::DIV_W'(sve_pkg::I32_MAX)) ? sve_pkg::I32_MAX
                                                             : sq_q[31:0];
        v_calc = keep ? vm : 32'(-vm);

        if (dh_reg == '0)
            w_calc = 32'd0;
        else if (!dh_reg[32])
            w_calc = (dt_reg == 24'd0 || rt_q > sve_pkg::DIV_W'(sve_pkg::I32_MAX))
                     ? sve_pkg::I32_MAX : rt_q[31:0];
        else
            w_calc = (dt_reg == 24'd0 || rt_q > sve_pkg::DIV_W'(sve_pkg::I32_MIN))
                     ? sve_pkg::I32_MIN : 32'(-rt_q[31:0]);

        assum = ssum[sve_pkg::SUM_W-1] ? sve_pkg::SUM_W'(-ssum) : sve_pkg::SUM_W'(ssum);
        arsum = rsum[sve_pkg::SUM_W-1] ? sve_pkg::SUM_W'(-rsum) : sve_pkg::SUM_W'(rsum);
        // quotient magnitude equals |average|, which feeds the deadband compare
        avg_s   = ssum[sve_pkg::SUM_W-1] ? 32'(-as_q[31:0]) : as_q[31:0];
        avg_r   = rsum[sve_pkg::SUM_W-1] ? 32'(-ar_q[31:0]) : ar_q[31:0];
        fv      = (as_q < sve_pkg::DIV_W'(sdb_reg)) ? 32'd0 : avg_s;
        fw      = (ar_q < sve_pkg::DIV_W'(rdb_reg)) ? 32'd0 : avg_r;
        spd_out = (fv == sve_pkg::I32_MIN) ? sve_pkg::I32_MAX : 32'(-fv);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg    <= {s_tdata[31], s_tdata[31:0]} - {lx_reg[31], lx_reg};
            dy_reg    <= {s_tdata[63], s_tdata[63:32]} - {ly_reg[31], ly_reg};
            dh_reg    <= {s_tdata[95], s_tdata[95:64]} - {lh_reg[31], lh_reg};
            h_reg     <= s_tdata[95:64];
            dt_reg    <= s_tdata[119:96];
            rt_reg    <= time_reg;
            fault_reg <= s_tdata[119:96] == 24'd0;
        end
        if (state_reg == sve_pkg::ST_MUL)
            prod_reg <= sve_pkg::DIV_W'(mag * sve_pkg::US_PER_S);
        if (state_reg == sve_pkg::ST_RD)
        begin
            v_reg <= v_calc;
            w_reg <= w_calc;
        end
        if (out_load)
        begin
            m_tdata_reg <= {rt_reg, fw, spd_out};
            m_tuser_reg <= fault_reg;
        end
    end

    sve_sqr u_sqx (.clk(clk), .rst_n(rst_n), .start(ld_units), .a(ax),
                   .done(sqx_done), .prod(sqx));
    sve_sqr u_sqy (.clk(clk), .rst_n(rst_n), .start(ld_units), .a(ay),
                   .done(sqy_done), .prod(sqy));

    sve_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_start),
                     .rad(sqx + sqy), .done(sqrt_done), .root(mag));

    sve_div u_sdiv (.clk(clk), .rst_n(rst_n), .start(sdiv_start),
                    .dividend(prod_reg), .divisor(dt_reg),
                    .done(sdiv_done), .quot(sq_q), .rem(sq_r));
    sve_div u_rdiv (.clk(clk), .rst_n(rst_n), .start(ld_units),
                    .dividend(sve_pkg::DIV_W'(adh * sve_pkg::US_PER_S)),
                    .divisor(dt_reg), .done(rdiv_done), .quot(rt_q), .rem(rt_r));
    // (heading + P) mod 2P
    sve_div u_mdiv (.clk(clk), .rst_n(rst_n), .start(ld_units),
                    .dividend(sve_pkg::DIV_W'(wrap_t[32:0])),
                    .divisor(sve_pkg::BAND_2P), .done(mdiv_done), .quot(md_q), .rem(md_r));

    sve_win u_win (.clk(clk), .rst_n(rst_n), .ctrl(wctl), .speed_in(v_reg),
                   .rate_in(w_reg), .speed_sum(ssum), .rate_sum(rsum));

    sve_div u_adiv_s (.clk(clk), .rst_n(rst_n), .start(avg_start),
                      .dividend(sve_pkg::DIV_W'(assum)), .divisor(sve_pkg::WIN_DIV),
                      .done(as_done), .quot(as_q), .rem(as_r));
    sve_div u_adiv_r (.clk(clk), .rst_n(rst_n), .start(avg_start),
                      .dividend(sve_pkg::DIV_W'(arsum)), .divisor(sve_pkg::WIN_DIV),
                      .done(ar_done), .quot(ar_q), .rem(ar_r));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== tb/sv/sve_checker.sv =====
// ----------------------------------------------------------------------------
// sve_checker
// Watches the pose and result channels and the register port of the signed
// velocity estimator. It predicts every result from accepted pose words and
// checks results field by field, in order.
// ----------------------------------------------------------------------------
module sve_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] yaw_rate;
        logic [31:0] record_time;
        logic        div_fault;
    } pose_result_t;

    localparam longint P_L  = 205849;
    localparam longint HP_L = 102924;
    localparam longint MAX_L = 64'sd2147483647;
    localparam longint MIN_L = -64'sd2147483648;

    pose_result_t result_q[$];

    logic [15:0] speed_db;
    logic [15:0] rate_db;
    logic [19:0] step_us;
    longint      prev_x, prev_y, prev_h;
    longint      speed_hist[sve_pkg::WINDOW];
    longint      rate_hist[sve_pkg::WINDOW];
    longint      speed_acc, rate_acc;
    int          slot;
    logic [31:0] rec_time;

    assign pending = result_q.size();

    function automatic longint root_floor(longint dx, longint dy);
        logic [69:0] rad;
        logic [69:0] cand;
        logic [34:0] r;
        longint      ax;
        longint      ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        rad = 70'(ax) * 70'(ax) + 70'(ay) * 70'(ay);
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            cand = 70'(r | (35'd1 << b));
            if (cand * cand <= rad)
                r = r | (35'd1 << b);
        end
        return longint'(r);
    endfunction

    function automatic longint wrap_h(longint h);
        longint m;
        if (h > -P_L && h < P_L)
            return h;
        m = (h + P_L) % (2 * P_L);
        if (m < 0)
            m += 2 * P_L;
        return m - P_L;
    endfunction

    function automatic bit sign_kept(longint dx, longint dy, longint yw);
        longint ay;
        ay = yw < 0 ? -yw : yw;
        if (dx > 0 && dy == 0) return ay > HP_L;
        if (dx == 0 && dy < 0) return yw > 0;
        if (dx < 0 && dy == 0) return ay < HP_L;
        if (dx == 0 && dy > 0) return yw < 0;
        if (dx > 0 && dy > 0) return yw < -HP_L && yw > -P_L;
        if (dx > 0 && dy < 0) return yw > HP_L && yw < P_L;
        if (dx < 0 && dy < 0) return yw > 0 && yw < HP_L;
        if (dx < 0 && dy > 0) return yw < 0 && yw > -HP_L;
        return 1'b1;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > MAX_L) return MAX_L;
        if (v < MIN_L) return MIN_L;
        return v;
    endfunction

    function automatic longint band_gate(longint v, logic [15:0] band);
        longint a;
        a = v < 0 ? -v : v;
        return a < longint'(band) ? 0 : v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic predict_pose(logic [119:0] w);
        pose_result_t e;
        longint x, y, h, dt, dx, dy, dh, mag, v, wr, fv, fw;
        x  = longint'(signed'(w[31:0]));
        y  = longint'(signed'(w[63:32]));
        h  = longint'(signed'(w[95:64]));
        dt = longint'(w[119:96]);
        dx = x - prev_x;
        dy = y - prev_y;
        dh = h - prev_h;
        mag = root_floor(dx, dy);
        if (dt == 0)
        begin
            v  = mag != 0 ? MAX_L : 0;
            wr = dh > 0 ? MAX_L : (dh < 0 ? MIN_L : 0);
        end
        else
        begin
            v  = mag * 1000000 / dt;
            if (v > MAX_L)
                v = MAX_L;
            wr = clamp32(dh * 1000000 / dt);
        end
        if (!sign_kept(dx, dy, wrap_h(h)))
            v = -v;
        speed_acc += v - speed_hist[slot];
        speed_hist[slot] = v;
        rate_acc += wr - rate_hist[slot];
        rate_hist[slot] = wr;
        slot = (slot + 1) % sve_pkg::WINDOW;
        fv = band_gate(speed_acc / sve_pkg::WINDOW, speed_db);
        fw = band_gate(rate_acc / sve_pkg::WINDOW, rate_db);
        prev_x = x;
        prev_y = y;
        prev_h = h;
        e.speed       = 32'(clamp32(-fv));
        e.yaw_rate    = 32'(clamp32(fw));
        e.record_time = rec_time;
        e.div_fault   = dt == 0;
        rec_time = rec_time + 32'(step_us);
        result_q.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_result_t e;
        if (!rst_n)
        begin
            speed_db  = sve_pkg::SPEED_DB_RST;
            rate_db   = sve_pkg::RATE_DB_RST;
            step_us   = sve_pkg::TIME_STEP_RST;
            prev_x    = 0;
            prev_y    = 0;
            prev_h    = 0;
            speed_acc = 0;
            rate_acc  = 0;
            slot      = 0;
            rec_time  = '0;
            fail_count = 0;
            for (int i = 0; i < sve_pkg::WINDOW; i++)
            begin
                speed_hist[i] = 0;
                rate_hist[i]  = 0;
            end
            result_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sve_pkg::CFG_SPEED_DB:  speed_db = cfg_data[15:0];
                    sve_pkg::CFG_RATE_DB:   rate_db  = cfg_data[15:0];
                    sve_pkg::CFG_TIME_STEP: step_us  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_pose(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report("unexpected word", m_tdata[31:0], 32'd0);
                else
                begin
                    e = result_q.pop_front();
                    if (m_tdata[31:0] !== e.speed)
                        report("speed", m_tdata[31:0], e.speed);
                    if (m_tdata[63:32] !== e.yaw_rate)
                        report("yaw_rate", m_tdata[63:32], e.yaw_rate);
                    if (m_tdata[95:64] !== e.record_time)
                        report("record_time", m_tdata[95:64], e.record_time);
                    if (m_tuser[0] !== e.div_fault)
                        report("div_fault", 32'(m_tuser[0]), 32'(e.div_fault));
                end
            end
        end
    end

endmodule

// ===== tb/sv/signed_velocity_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// signed_velocity_estimator_tb
// Drives pose words in bursts, with directed edge cases and random motion
// tracks, rewrites the registers between phases, and stalls the result side.
// The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module signed_velocity_estimator_tb;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [19:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           cycle_cnt;
    bit           hold_off;
    bit           stall_on;
    logic [31:0]  trk_x, trk_y, trk_h;

    localparam int LIMIT = 2000000;
    localparam int DRAIN = 400;

    signed_velocity_estimator i_dut (.*);

    sve_checker i_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 300);
                m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] h,
                             logic [23:0] dt);
        s_tvalid <= 1'b1;
        s_tdata  <= {dt, h, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 400)) @(posedge clk);
        end
    endtask

    // called only once the sender has already dropped s_tvalid
    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [31:0] vx, vy, vh;
        int burst;
        vx = $urandom_range(0, 200000) - 100000;
        vy = $urandom_range(0, 200000) - 100000;
        vh = $urandom_range(0, 40000) - 20000;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            case ($urandom_range(0, 9))
                0:
                begin
                    trk_x = $urandom;
                    trk_y = $urandom;
                    trk_h = $urandom;
                end
                1:
                begin
                    vx = $urandom_range(0, 2000000) - 1000000;
                    vy = $urandom_range(0, 2) == 0 ? 32'd0 : 32'($urandom_range(0, 2000000) - 1000000);
                    vh = $urandom_range(0, 400000) - 200000;
                end
                default:
                begin
                    trk_x = trk_x + vx + ($urandom_range(0, 64) - 32);
                    trk_y = trk_y + vy + ($urandom_range(0, 64) - 32);
                    trk_h = trk_h + vh;
                end
            endcase
            send_word(trk_x, trk_y, trk_h,
                      $urandom_range(0, 30) == 0 ? 24'd0 :
                      ($urandom_range(0, 20) == 0 ? 24'($urandom) :
                       24'($urandom_range(5000, 15000))));
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = sve_pkg::CFG_SPEED_DB;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        hold_off  = 1'b0;
        stall_on  = 1'b0;
        trk_x = '0;
        trk_y = '0;
        trk_h = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: axes, quadrants, wraps, zero dt, extremes
        send_word(32'd0, 32'd0, 32'd0, 24'd9524);
        send_word(32'd65536, 32'd0, 32'd0, 24'd9524);
        send_word(32'd0, 32'd0, 32'd300000, 24'd9524);
        send_word(32'd0, 32'd65536, 32'hfffd0000, 24'd9524);
        send_word(32'd0, 32'd0, 32'd205849, 24'd0);
        send_word(32'd0, 32'd0, 32'd205849, 24'd0);
        send_word(32'd100, 32'd100, -32'sd150000, 24'd1);
        send_word(32'd0, 32'd200, 32'd50000, 24'd10000);
        send_word(32'd100, 32'd0, -32'sd50000, 24'd10000);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'd1);
        send_word(32'h80000000, 32'h80000000, 32'h80000000, 24'd1);
        send_word(32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'hffffff);
        send_word(32'h80000000, 32'h7fffffff, -32'sd205849, 24'd0);
        send_word(32'h80000000, 32'h7fffffff, 32'd411698, 24'd0);
        send_word(32'd0, 32'd0, 32'd0, 24'hffffff);
        send_word(32'd0, 32'd0, 32'd0, 24'd0);
        send_word(32'd5, 32'hfffffffb, 32'd102925, 24'd7);
        send_word(32'd0, 32'hfffffff0, 32'd102924, 24'd7);

        stall_on = 1'b1;
        random_phase(150);

        write_reg(sve_pkg::CFG_SPEED_DB, 20'd0);
        write_reg(sve_pkg::CFG_RATE_DB, 20'd0);
        write_reg(sve_pkg::CFG_TIME_STEP, 20'd1000000);
        hold_off = 1'b1;
        random_phase(150);

        write_reg(sve_pkg::CFG_SPEED_DB, 20'hfffff);
        write_reg(sve_pkg::CFG_RATE_DB, 20'hfffff);
        write_reg(sve_pkg::CFG_TIME_STEP, 20'd0);
        stall_on = 1'b0;
        random_phase(150);

        write_reg(sve_pkg::CFG_SPEED_DB, 20'($urandom));
        write_reg(sve_pkg::CFG_RATE_DB, 20'($urandom));
        write_reg(sve_pkg::CFG_TIME_STEP, 20'd1);
        write_reg(2'd3, 20'($urandom));
        stall_on = 1'b1;
        random_phase(150);

        write_reg(sve_pkg::CFG_SPEED_DB, 20'd983);
        write_reg(sve_pkg::CFG_RATE_DB, 20'd655);
        write_reg(sve_pkg::CFG_TIME_STEP, 20'($urandom_range(1, 1000000)));
        hold_off = 1'b1;
        random_phase(150);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sve_pkg.sv
rtl/sve_div.sv
rtl/sve_sqr.sv
rtl/sve_sqrt.sv
rtl/sve_win.sv
rtl/signed_velocity_estimator.sv
tb/sv/sve_checker.sv
tb/sv/signed_velocity_estimator_tb.sv
